[rtl/core/ctf1_pkg.sv]
package ctf1_pkg;

  localparam int LABEL_W = 8;
  localparam int TAG_W   = 2;
  localparam int TYPE_W  = 6;
  localparam int CNT_W   = 32;
  localparam int MASK_W  = 32;
  localparam int NCT_W   = 6;

  // Chunk type count after reset; it is also the other type code then.
  localparam logic [NCT_W-1:0] NCT_RESET = NCT_W'(1);

  typedef enum logic [1:0] {
    SCH_PLAIN = 2'd0,
    SCH_IOB   = 2'd1,
    SCH_IOE   = 2'd2,
    SCH_IOBES = 2'd3
  } scheme_t;

  typedef enum logic [1:0] {
    CFG_SCHEME  = 2'd0,
    CFG_NUM_TYP = 2'd1,
    CFG_EXCL    = 2'd2
  } cfg_idx_t;

  // A chunk that closes on this token; its begin position travels beside it.
  typedef struct packed {
    logic              valid;
    logic [TYPE_W-1:0] ctype;
  } chunk_close_t;

  function automatic logic is_begin(scheme_t sc, logic [TAG_W-1:0] t);
    logic r;
    r = 1'b0;
    case (sc)
      SCH_IOB, SCH_IOBES: r = (t == TAG_W'(0));
      default:            r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_inside(scheme_t sc, logic [TAG_W-1:0] t);
    logic r;
    r = 1'b0;
    case (sc)
      SCH_IOB:   r = (t == TAG_W'(1));
      SCH_IOE:   r = (t == TAG_W'(0));
      SCH_IOBES: r = (t == TAG_W'(1));
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_end(scheme_t sc, logic [TAG_W-1:0] t);
    logic r;
    r = 1'b0;
    case (sc)
      SCH_IOE:   r = (t == TAG_W'(1));
      SCH_IOBES: r = (t == TAG_W'(2));
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_single(scheme_t sc, logic [TAG_W-1:0] t);
    return (sc == SCH_IOBES) && (t == TAG_W'(3));
  endfunction

  function automatic logic ends_chunk(scheme_t sc, logic [TAG_W-1:0] pt,
                                      logic [TYPE_W-1:0] pty, logic [TAG_W-1:0] t,
                                      logic [TYPE_W-1:0] ty, logic [TYPE_W-1:0] oth);
    logic r;
    r = 1'b0;
    if (pty == oth) begin
      r = 1'b0;
    end else if (ty == oth || ty != pty) begin
      r = 1'b1;
    end else if (is_begin(sc, pt) || is_inside(sc, pt)) begin
      r = is_begin(sc, t) || is_single(sc, t);
    end else begin
      r = is_end(sc, pt) || is_single(sc, pt);
    end
    return r;
  endfunction

  function automatic logic begins_chunk(scheme_t sc, logic [TAG_W-1:0] pt,
                                        logic [TYPE_W-1:0] pty, logic [TAG_W-1:0] t,
                                        logic [TYPE_W-1:0] ty, logic [TYPE_W-1:0] oth);
    logic r;
    r = 1'b0;
    if (pty == oth) begin
      r = (ty != oth);
    end else if (ty == oth) begin
      r = 1'b0;
    end else if (ty != pty) begin
      r = 1'b1;
    end else if (is_begin(sc, t) || is_single(sc, t)) begin
      r = 1'b1;
    end else if (is_inside(sc, t) || is_end(sc, t)) begin
      r = is_end(sc, pt) || is_single(sc, pt);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  // Types 32 and above have no mask bit and are always counted.
  function automatic logic is_excluded(logic [MASK_W-1:0] mask, logic [TYPE_W-1:0] ty);
    return !ty[TYPE_W-1] && mask[ty[4:0]];
  endfunction

endpackage

[rtl/core/ctf1_stream.sv]
module ctf1_stream #(
  parameter int POS_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  ctf1_pkg::scheme_t             scheme,
  input  logic [ctf1_pkg::TYPE_W-1:0]   oth,
  input  logic [ctf1_pkg::LABEL_W-1:0]  label,
  input  logic                          last,
  input  logic [POS_W-1:0]              pos,
  output ctf1_pkg::chunk_close_t        mid,
  output logic [POS_W-1:0]              mid_begin,
  output ctf1_pkg::chunk_close_t        fin,
  output logic [POS_W-1:0]              fin_begin,
  output logic                          err,
  output logic                          open
);

  logic                          open_r, open_nxt;
  logic [POS_W-1:0]              begin_r, begin_nxt;
  logic [ctf1_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [ctf1_pkg::TYPE_W-1:0]   ptype_r, ptype_nxt;

  logic [1:0]                    sh;
  logic [ctf1_pkg::LABEL_W-1:0]  lim;
  logic [ctf1_pkg::TAG_W-1:0]    tag;
  logic [ctf1_pkg::TYPE_W-1:0]   ctype;
  logic                          ends, begins, open1;
  logic [POS_W-1:0]              begin1;

  always_comb begin
    // Tags per type: plain 1, IOB and IOE 2, IOBES 4, so split by shift and mask.
    case (scheme)
      ctf1_pkg::SCH_PLAIN: sh = 2'd0;
      ctf1_pkg::SCH_IOBES: sh = 2'd2;
      default:             sh = 2'd1;
    endcase
    lim = {2'b00, oth} << sh;
    err = label > lim;
    if (err) begin
      tag   = '0;
      ctype = oth;
    end else begin
      tag   = label[ctf1_pkg::TAG_W-1:0] & ~({ctf1_pkg::TAG_W{1'b1}} << sh);
      ctype = ctf1_pkg::TYPE_W'(label >> sh);
    end

    ends   = ctf1_pkg::ends_chunk(scheme, tag_r, ptype_r, tag, ctype, oth);
    begins = ctf1_pkg::begins_chunk(scheme, tag_r, ptype_r, tag, ctype, oth);

    mid.valid = open_r && ends;
    mid.ctype = ptype_r;
    mid_begin = begin_r;

    open1  = (open_r && !ends) || begins;
    begin1 = begins ? pos : begin_r;

    // At the end of a sequence the open chunk is reported with this token's type.
    fin.valid = last && open1;
    fin.ctype = ctype;
    fin_begin = begin1;

    if (last) begin
      open_nxt  = 1'b0;
      begin_nxt = '0;
      tag_nxt   = '0;
      ptype_nxt = oth;
    end else begin
      open_nxt  = open1;
      begin_nxt = begin1;
      tag_nxt   = tag;
      ptype_nxt = ctype;
    end
  end

  assign open = open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      begin_r <= '0;
      tag_r   <= '0;
      ptype_r <= ctf1_pkg::NCT_RESET;
    end else if (adv) begin
      open_r  <= open_nxt;
      begin_r <= begin_nxt;
      tag_r   <= tag_nxt;
      ptype_r <= ptype_nxt;
    end
  end

endmodule

[rtl/core/ctf1_count.sv]
module ctf1_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          clr,
  input  logic [ctf1_pkg::MASK_W-1:0]   mask,
  input  ctf1_pkg::chunk_close_t        pm,
  input  ctf1_pkg::chunk_close_t        pf,
  input  ctf1_pkg::chunk_close_t        tm,
  input  ctf1_pkg::chunk_close_t        tf,
  input  logic                          mid_same_begin,
  input  logic                          fin_same_begin,
  output logic [ctf1_pkg::CNT_W-1:0]    true_cnt,
  output logic [ctf1_pkg::CNT_W-1:0]    pred_cnt,
  output logic [ctf1_pkg::CNT_W-1:0]    corr_cnt
);

  localparam int W = ctf1_pkg::CNT_W;

  logic [W-1:0] true_r, true_nxt, pred_r, pred_nxt, corr_r, corr_nxt;
  logic         t_mid, t_fin, p_mid, p_fin, c_mid, c_fin;

  function automatic logic [W-1:0] sat_add(logic [W-1:0] base, logic a, logic b);
    logic [W:0] s;
    s = {1'b0, base} + (W+1)'(a) + (W+1)'(b);
    return s[W] ? {W{1'b1}} : s[W-1:0];
  endfunction

  always_comb begin
    t_mid = tm.valid && !ctf1_pkg::is_excluded(mask, tm.ctype);
    t_fin = tf.valid && !ctf1_pkg::is_excluded(mask, tf.ctype);
    p_mid = pm.valid && !ctf1_pkg::is_excluded(mask, pm.ctype);
    p_fin = pf.valid && !ctf1_pkg::is_excluded(mask, pf.ctype);
    c_mid = p_mid && tm.valid && mid_same_begin && (pm.ctype == tm.ctype);
    c_fin = p_fin && tf.valid && fin_same_begin && (pf.ctype == tf.ctype);
    // A clear request zeroes the counts before this token's chunks are added.
    true_nxt = sat_add(clr ? '0 : true_r, t_mid, t_fin);
    pred_nxt = sat_add(clr ? '0 : pred_r, p_mid, p_fin);
    corr_nxt = sat_add(clr ? '0 : corr_r, c_mid, c_fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      true_r <= '0;
      pred_r <= '0;
      corr_r <= '0;
    end else if (adv) begin
      true_r <= true_nxt;
      pred_r <= pred_nxt;
      corr_r <= corr_nxt;
    end
  end

  assign true_cnt = true_r;
  assign pred_cnt = pred_r;
  assign corr_cnt = corr_r;

endmodule

[rtl/core/chunk_tag_f1_counter.sv]
// Pipeline: a request is captured in the input register at its accepting edge, and its
// result is loaded into the count registers, which form the result register, when it
// advances (it waits while a result is untaken); out_tvalid rises with that load.
// Throughput: one request per cycle unless the output stalls; the per-token decode and
// count update is a single pass of compares and a saturating add between those
// registers. Reset (rst_n low at a clock edge) clears both pipeline stages, the chunk
// tracking state, the position and the counts, and loads the register defaults.
module chunk_tag_f1_counter #(
  parameter int              MAX_CHUNK_TYPES = 32,
  parameter longint unsigned MAX_SEQ_LEN     = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [7:0] predicted_label, [15:8] true_label
  input  logic         in_tlast,
  input  logic         in_tuser,   // [0] clear_counts
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] true_chunk_count, [63:32] predicted_chunk_count, [95:64] correct_chunk_count
  output logic [95:0]  out_tdata,
  output logic         out_tuser,  // [0] label_error
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  localparam int POS_W = $clog2(MAX_SEQ_LEN);
  localparam int LW    = ctf1_pkg::LABEL_W;

  ctf1_pkg::scheme_t              scheme_r;
  logic [ctf1_pkg::NCT_W-1:0]     nct_r;
  logic [ctf1_pkg::MASK_W-1:0]    mask_r;
  logic [ctf1_pkg::TYPE_W-1:0]    oth;

  logic            s1_v_r, s1_last_r, s1_clr_r;
  logic [LW-1:0]   s1_pred_r, s1_true_r;
  logic            out_valid_r, out_valid_nxt, err_r;
  logic            adv;
  logic [POS_W-1:0] pos_r, pos_nxt;

  ctf1_pkg::chunk_close_t pm, pf, tm, tf;
  logic [POS_W-1:0] pm_b, pf_b, tm_b, tf_b;
  logic             p_err, t_err, p_open, t_open;
  logic [ctf1_pkg::CNT_W-1:0] true_cnt, pred_cnt, corr_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= ctf1_pkg::SCH_IOE;
      nct_r    <= ctf1_pkg::NCT_RESET;
      mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ctf1_pkg::CFG_SCHEME:  scheme_r <= ctf1_pkg::scheme_t'(cfg_wdata[1:0]);
        ctf1_pkg::CFG_NUM_TYP: nct_r    <= cfg_wdata[ctf1_pkg::NCT_W-1:0];
        ctf1_pkg::CFG_EXCL:    mask_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign oth = (nct_r > ctf1_pkg::NCT_W'(MAX_CHUNK_TYPES))
             ? ctf1_pkg::TYPE_W'(MAX_CHUNK_TYPES) : nct_r;

  // The counts are held while a result waits, since the next token only
  // advances once the output register is free.
  assign adv       = s1_v_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign out_valid_nxt = adv ? 1'b1 : (out_valid_r && !out_tready);

  always_comb begin
    if (s1_last_r || pos_r == POS_W'(MAX_SEQ_LEN - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      s1_v_r      <= (in_tvalid && in_tready) || (s1_v_r && !adv);
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        pos_r <= pos_nxt;
        err_r <= p_err || t_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pred_r <= in_tdata[LW-1:0];
      s1_true_r <= in_tdata[2*LW-1:LW];
      s1_last_r <= in_tlast;
      s1_clr_r  <= in_tuser;
    end
  end

  ctf1_stream #(.POS_W(POS_W)) u_pred (
    .clk, .rst_n, .adv,
    .scheme(scheme_r), .oth, .label(s1_pred_r), .last(s1_last_r), .pos(pos_r),
    .mid(pm), .mid_begin(pm_b), .fin(pf), .fin_begin(pf_b),
    .err(p_err), .open(p_open)
  );

  ctf1_stream #(.POS_W(POS_W)) u_true (
    .clk, .rst_n, .adv,
    .scheme(scheme_r), .oth, .label(s1_true_r), .last(s1_last_r), .pos(pos_r),
    .mid(tm), .mid_begin(tm_b), .fin(tf), .fin_begin(tf_b),
    .err(t_err), .open(t_open)
  );

  ctf1_count u_count (
    .clk, .rst_n, .adv,
    .clr(s1_clr_r), .mask(mask_r),
    .pm, .pf, .tm, .tf,
    .mid_same_begin(pm_b == tm_b), .fin_same_begin(pf_b == tf_b),
    .true_cnt, .pred_cnt, .corr_cnt
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {corr_cnt, pred_cnt, true_cnt};
  assign out_tuser  = err_r;

  a_corr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (corr_cnt <= true_cnt) && (corr_cnt <= pred_cnt))
    else $error("correct count exceeds a chunk count");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> !p_open && !t_open && (pos_r == '0))
    else $error("chunks still open or position not restarted after last token");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !adv)
    else $error("token advanced while a result was still waiting");

endmodule
